// ----- hw/rtl/vbab_pkg.sv -----
package vbab_pkg;

    // Coordinate width actually used from each 32-bit field
    localparam int COORD_WIDTH = 32;
    localparam int FIELD_W     = 32;

    // Exact difference (signed) and its magnitude (unsigned)
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int MAG_W  = COORD_WIDTH + 1;

    // Angle and 8.8 bound widths (a bound reaches 256.0)
    localparam int ANG_W  = 8;
    localparam int FRAC_W = 8;
    localparam int BND_W  = ANG_W + FRAC_W + 1;

    // Bisection step counter
    localparam int          STEP_W    = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(6);

    // Fixed angles and quadrant bounds
    localparam logic [ANG_W-1:0] ANG_POS_Y = ANG_W'(0);
    localparam logic [ANG_W-1:0] ANG_POS_X = ANG_W'(64);
    localparam logic [ANG_W-1:0] ANG_NEG_Y = ANG_W'(128);
    localparam logic [ANG_W-1:0] ANG_NEG_X = ANG_W'(192);

    localparam logic [BND_W-1:0] BND_0    = BND_W'(0);
    localparam logic [BND_W-1:0] BND_64   = BND_W'(64 * 256);
    localparam logic [BND_W-1:0] BND_128  = BND_W'(128 * 256);
    localparam logic [BND_W-1:0] BND_192  = BND_W'(192 * 256);
    localparam logic [BND_W-1:0] BND_256  = BND_W'(256 * 256);
    localparam logic [BND_W-1:0] HALF_RND = BND_W'(128);

    // Result of the shared compare/subtract unit
    typedef struct packed {
        logic             lt;
        logic             eq;
        logic [MAG_W-1:0] diff;
    } t_cmp;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SETUP  = 4'b0010,
        S_STEP   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    // Place a whole-unit angle in 8.8 form
    function automatic logic [BND_W-1:0] ang_to_bnd(input logic [ANG_W-1:0] a);
        ang_to_bnd = {1'b0, a, {FRAC_W{1'b0}}};
    endfunction

endpackage

// ----- hw/rtl/vbab_alu.sv -----
module vbab_alu (
    input  logic [vbab_pkg::MAG_W-1:0] i_a,
    input  logic [vbab_pkg::MAG_W-1:0] i_b,
    output vbab_pkg::t_cmp             o_res
);
    import vbab_pkg::*;

    logic [MAG_W:0] w_ab;
    logic [MAG_W:0] w_ba;

    // Subtract both ways; the borrow picks the smaller magnitude
    assign w_ab = {1'b0, i_a} - {1'b0, i_b};
    assign w_ba = {1'b0, i_b} - {1'b0, i_a};

    assign o_res.lt   = w_ab[MAG_W];
    assign o_res.eq   = (i_a == i_b);
    assign o_res.diff = w_ab[MAG_W] ? w_ba[MAG_W-1:0] : w_ab[MAG_W-1:0];

endmodule

// ----- hw/rtl/vector_binary_angle_bisection.sv -----
// Channel   | valid        | stall        | payload
// ----------+--------------+--------------+--------------------------------------------
// request   | i_in_valid   | o_in_stall   | i_source_x, i_source_y, i_target_x, i_target_y
// result    | o_out_valid  | i_out_stall  | o_heading
//
// A request goes from acceptance through set-up and n passes through the shared
// compare/subtract unit to the result register, where n is 0 for a zero or axis
// vector, otherwise 1 to 7. A full result register under stall delays the load.
// The request side stalls from acceptance until the result is loaded.
// The result waits in its own register; the next request is taken meanwhile.
// Synchronous active-low reset clears the sequencer and the result valid.
module vector_binary_angle_bisection (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [vbab_pkg::FIELD_W-1:0]  i_source_x,
    input  logic [vbab_pkg::FIELD_W-1:0]  i_source_y,
    input  logic [vbab_pkg::FIELD_W-1:0]  i_target_x,
    input  logic [vbab_pkg::FIELD_W-1:0]  i_target_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vbab_pkg::ANG_W-1:0]    o_heading
);
    import vbab_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [MAG_W-1:0]      r_ax;
    logic [MAG_W-1:0]      r_ay;
    logic [BND_W-1:0]      r_b0;
    logic [BND_W-1:0]      r_b1;
    logic                  r_xhi;
    logic [STEP_W-1:0]     r_step_cnt;
    logic                  r_out_valid;
    logic [ANG_W-1:0]      r_heading;

    logic                  w_in_acc;
    logic                  w_out_load;
    logic signed [DIFF_W-1:0] w_sx, w_sy, w_tx, w_ty;
    logic [BND_W:0]        w_sum;
    logic [BND_W-1:0]      w_mid;
    logic [BND_W-1:0]      w_rnd;
    t_cmp                  w_cmp;

    // Read the low coordinate bits as two's complement
    assign w_sx = {i_source_x[COORD_WIDTH-1], i_source_x[COORD_WIDTH-1:0]};
    assign w_sy = {i_source_y[COORD_WIDTH-1], i_source_y[COORD_WIDTH-1:0]};
    assign w_tx = {i_target_x[COORD_WIDTH-1], i_target_x[COORD_WIDTH-1:0]};
    assign w_ty = {i_target_y[COORD_WIDTH-1], i_target_y[COORD_WIDTH-1:0]};

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // Midpoint of the bounds and its rounded angle
    assign w_sum = {1'b0, r_b0} + {1'b0, r_b1};
    assign w_mid = w_sum[BND_W:1];
    assign w_rnd = w_mid + HALF_RND;

    // Shared compare/subtract unit on the two magnitudes
    vbab_alu u_alu (
        .i_a   (r_ax),
        .i_b   (r_ay),
        .o_res (w_cmp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (r_dx == '0 || r_dy == '0) n_state = S_FINISH;
                else                           n_state = S_STEP;
            end
            S_STEP: begin
                if (w_cmp.eq || r_step_cnt == LAST_STEP) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load)                     r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Form exact differences on acceptance
        if (w_in_acc) begin
            r_dx <= w_tx - w_sx;
            r_dy <= w_ty - w_sy;
        end

        // Take magnitudes and set the quadrant bounds
        if (r_state == S_SETUP) begin
            r_ax       <= r_dx[DIFF_W-1] ? MAG_W'(-r_dx) : MAG_W'(r_dx);
            r_ay       <= r_dy[DIFF_W-1] ? MAG_W'(-r_dy) : MAG_W'(r_dy);
            r_step_cnt <= '0;
            if (r_dx == '0) begin
                // Axis cases collapse both bounds onto the fixed angle
                r_b0 <= r_dy[DIFF_W-1] ? ang_to_bnd(ANG_NEG_Y) : ang_to_bnd(ANG_POS_Y);
                r_b1 <= r_dy[DIFF_W-1] ? ang_to_bnd(ANG_NEG_Y) : ang_to_bnd(ANG_POS_Y);
                r_xhi <= 1'b0;
            end else if (r_dy == '0) begin
                r_b0 <= r_dx[DIFF_W-1] ? ang_to_bnd(ANG_NEG_X) : ang_to_bnd(ANG_POS_X);
                r_b1 <= r_dx[DIFF_W-1] ? ang_to_bnd(ANG_NEG_X) : ang_to_bnd(ANG_POS_X);
                r_xhi <= 1'b0;
            end else if (!r_dx[DIFF_W-1] && !r_dy[DIFF_W-1]) begin
                r_b0 <= BND_0;   r_b1 <= BND_64;  r_xhi <= 1'b1;
            end else if (!r_dx[DIFF_W-1]) begin
                r_b0 <= BND_64;  r_b1 <= BND_128; r_xhi <= 1'b0;
            end else if (r_dy[DIFF_W-1]) begin
                r_b0 <= BND_128; r_b1 <= BND_192; r_xhi <= 1'b1;
            end else begin
                r_b0 <= BND_192; r_b1 <= BND_256; r_xhi <= 1'b0;
            end
        end

        // Advance one bisection step unless the magnitudes already match
        if (r_state == S_STEP && !w_cmp.eq) begin
            r_step_cnt <= r_step_cnt + STEP_W'(1);
            if (w_cmp.lt) begin
                r_ay <= w_cmp.diff;
                if (r_xhi) r_b1 <= w_mid;
                else       r_b0 <= w_mid;
            end else begin
                r_ax <= w_cmp.diff;
                if (r_xhi) r_b0 <= w_mid;
                else       r_b1 <= w_mid;
            end
        end

        // Hold the rounded result for the output side
        if (w_out_load) r_heading <= w_rnd[FRAC_W +: ANG_W];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_heading   = r_heading;

endmodule

// ----- hw/rtl/vbab_checker.sv -----
module vbab_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_heading
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_heading))
        else $error("result dropped or changed while stalled");

    // Stall the request side in the cycle after a request is taken
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request side not busy after acceptance");

    // Keep the request side stalled through set-up and the cycle after it
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##1 o_in_stall)
        else $error("request finished too early");

    // Leave reset idle and empty
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not cleared by reset");

endmodule

bind vector_binary_angle_bisection vbab_checker u_vbab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_heading   (o_heading)
);

// ----- bench/vector_binary_angle_bisection_tb.sv -----
`timescale 1ns / 1ps

module vector_binary_angle_bisection_tb;
    import vbab_pkg::*;

    localparam int MAX_SHOWN = 10;

    // Predicted headings in request order, checked against each delivered result
    class heading_scoreboard;
        logic [ANG_W-1:0] pending_headings[$];
        int               mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Read the low COORD_WIDTH bits as two's complement
        function automatic longint coord_of(logic [FIELD_W-1:0] raw);
            longint v;
            v = longint'(raw);
            v = (v << (64 - COORD_WIDTH)) >>> (64 - COORD_WIDTH);
            return v;
        endfunction

        // Bisect between the quadrant bounds in 8.8 form
        function automatic logic [ANG_W-1:0] heading_for(logic [FIELD_W-1:0] sx,
                                                         logic [FIELD_W-1:0] sy,
                                                         logic [FIELD_W-1:0] tx,
                                                         logic [FIELD_W-1:0] ty);
            longint dx, dy, ax, ay;
            int     lo_b, hi_b, mid;
            bit     x_on_hi;
            dx = coord_of(tx) - coord_of(sx);
            dy = coord_of(ty) - coord_of(sy);
            if (dx == 0 && dy == 0) return ANG_POS_Y;
            if (dx == 0) return (dy < 0) ? ANG_NEG_Y : ANG_POS_Y;
            if (dy == 0) return (dx < 0) ? ANG_NEG_X : ANG_POS_X;
            if (dx > 0 && dy > 0) begin
                lo_b = int'(BND_0);   hi_b = int'(BND_64);  x_on_hi = 1'b1;
            end else if (dx > 0) begin
                lo_b = int'(BND_64);  hi_b = int'(BND_128); x_on_hi = 1'b0;
            end else if (dy < 0) begin
                lo_b = int'(BND_128); hi_b = int'(BND_192); x_on_hi = 1'b1;
            end else begin
                lo_b = int'(BND_192); hi_b = int'(BND_256); x_on_hi = 1'b0;
            end
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            mid = (lo_b + hi_b) >> 1;
            if (ax != ay) begin
                do begin
                    if (ax < ay) begin
                        ay -= ax;
                        if (x_on_hi) hi_b = mid; else lo_b = mid;
                    end else begin
                        ax -= ay;
                        if (x_on_hi) lo_b = mid; else hi_b = mid;
                    end
                    mid = (lo_b + hi_b) >> 1;
                end while ((hi_b - lo_b) >= (1 << FRAC_W) && ax != ay);
            end
            return ANG_W'((mid + int'(HALF_RND)) >> FRAC_W);
        endfunction

        function void note_request(logic [FIELD_W-1:0] sx, logic [FIELD_W-1:0] sy,
                                   logic [FIELD_W-1:0] tx, logic [FIELD_W-1:0] ty);
            pending_headings.push_back(heading_for(sx, sy, tx, ty));
        endfunction

        function void check_heading(logic [ANG_W-1:0] actual);
            logic [ANG_W-1:0] predicted;
            if (pending_headings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected heading %0d with no request waiting", actual);
                return;
            end
            predicted = pending_headings.pop_front();
            if (actual !== predicted) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("heading mismatch: expected %0d, got %0d", predicted, actual);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [FIELD_W-1:0] i_source_x;
    logic [FIELD_W-1:0] i_source_y;
    logic [FIELD_W-1:0] i_target_x;
    logic [FIELD_W-1:0] i_target_y;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [ANG_W-1:0]   o_heading;

    heading_scoreboard sb;
    int                sender_idle_pct;
    int                recv_idle_pct;

    vector_binary_angle_bisection DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_source_x  (i_source_x),
        .i_source_y  (i_source_y),
        .i_target_x  (i_target_x),
        .i_target_y  (i_target_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_heading   (o_heading)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Take results and draw the next stall; values read here are pre-edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_heading(o_heading);
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Idle at random, then hold the request until it is taken
    task automatic send_request(input logic [FIELD_W-1:0] sx, input logic [FIELD_W-1:0] sy,
                                input logic [FIELD_W-1:0] tx, input logic [FIELD_W-1:0] ty);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_source_x <= sx;
        i_source_y <= sy;
        i_target_x <= tx;
        i_target_y <= ty;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(sx, sy, tx, ty);
    endtask

    function automatic logic [FIELD_W-1:0] corner_value();
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mix of wide random points, close pairs, diagonals, axes and corners
    task automatic send_random();
        logic [FIELD_W-1:0] sx, sy, tx, ty;
        int                 dx, dy, mag;
        sx = $urandom;
        sy = $urandom;
        case ($urandom_range(9))
            0, 1, 2: begin
                tx = $urandom;
                ty = $urandom;
            end
            3, 4, 5: begin
                dx = int'($urandom_range(600)) - 300;
                dy = int'($urandom_range(600)) - 300;
                tx = sx + dx;
                ty = sy + dy;
            end
            6: begin
                sx = $signed(sx) >>> 2;
                sy = $signed(sy) >>> 2;
                mag = $urandom_range(1, 32'h2000_0000);
                tx = $urandom_range(1) ? sx + mag : sx - mag;
                ty = $urandom_range(1) ? sy + mag : sy - mag;
            end
            7: begin
                sx = $signed(sx) >>> 2;
                sy = $signed(sy) >>> 2;
                mag = $urandom_range(0, 32'h2000_0000);
                if ($urandom_range(1)) mag = -mag;
                tx = sx;
                ty = sy;
                if ($urandom_range(1)) tx = sx + mag; else ty = sy + mag;
            end
            8: begin
                sx = $signed(sx) >>> 4;
                sy = $signed(sy) >>> 4;
                dx = $urandom_range(1 << 20);
                dy = $urandom_range(1 << 20);
                tx = $urandom_range(1) ? sx + dx : sx - dx;
                ty = $urandom_range(1) ? sy + dy : sy - dy;
            end
            default: begin
                sx = corner_value();
                sy = corner_value();
                tx = corner_value();
                ty = corner_value();
            end
        endcase
        send_request(sx, sy, tx, ty);
    endtask

    initial begin
        sb = new();
        sender_idle_pct = 29;
        recv_idle_pct   = 74;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_source_x <= '0;
        i_source_y <= '0;
        i_target_x <= '0;
        i_target_y <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero vector, including a non-zero point against itself
        send_request(32'h0, 32'h0, 32'h0, 32'h0);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        // Vertical and horizontal, small and full span
        send_request(32'h0, 32'h0, 32'h0, 32'h10);
        send_request(32'h5, 32'h7FFF_FFFF, 32'h5, 32'h8000_0000);
        send_request(32'h8000_0000, 32'h3, 32'h7FFF_FFFF, 32'h3);
        send_request(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        // Equal magnitudes in each quadrant and at full span
        send_request(32'h0, 32'h0, 32'h5, 32'h5);
        send_request(32'h0, 32'h0, 32'h5, 32'hFFFF_FFFB);
        send_request(32'h0, 32'h0, 32'hFFFF_FFFB, 32'hFFFF_FFFB);
        send_request(32'h0, 32'h0, 32'hFFFF_FFFB, 32'h5);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        // Steep and shallow at the extremes, every quadrant
        send_request(32'h0, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h1);
        send_request(32'h0, 32'h0, 32'h3, 32'h7);
        send_request(32'h0, 32'h0, 32'h7, 32'hFFFF_FFFD);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_request(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);

        // Random part over the three idling regimes
        repeat (350) send_random();
        sender_idle_pct = 74;
        recv_idle_pct   = 29;
        repeat (350) send_random();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        repeat (350) send_random();
        i_in_valid <= 1'b0;

        // Drain outstanding headings, then allow the pipeline to settle
        while (sb.pending_headings.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_headings.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
